/* hw/rtl/prfe_pkg.sv */
// shared constants and types for the pointer report frame engine
package prfe_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int BTN_FIELD_W = 3;
  localparam int DELTA_W = 16;
  localparam int WHEEL_W = 8;
  localparam int CNT_W = 8;
  localparam int STATUS_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DBNC_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TIMEOUT = 1'd1;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd16;
  localparam logic [CNT_W-1:0] SLEEP_RESET = 8'd240;

  localparam logic [STATUS_W-1:0] STATUS_SYNC = 8'h40;
  localparam logic [STATUS_W-1:0] STATUS_FIRST = 8'h80;

  typedef struct packed {
    logic               moved;
    logic [WHEEL_W-1:0] total;
  } wheel_stat_t;

endpackage

/* hw/rtl/prfe_wheel.sv */
// half-step quadrature wheel decoder with wrapping total
module prfe_wheel
  import prfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        wheel_a,
  input  logic        wheel_b,
  output wheel_stat_t stat
);

  logic               last_same_r, last_same_nxt;
  logic               last_diff_r, last_diff_nxt;
  logic [WHEEL_W-1:0] total_r, total_nxt;
  logic               moved;

  always_comb begin
    last_same_nxt = last_same_r;
    last_diff_nxt = last_diff_r;
    total_nxt = total_r;
    moved = 1'b0;
    if (wheel_a != wheel_b) begin
      last_diff_nxt = wheel_a;
    end else if (wheel_a != last_same_r) begin
      if (wheel_a ^ last_diff_r) begin
        total_nxt = total_r + WHEEL_W'(1);
      end else begin
        total_nxt = total_r - WHEEL_W'(1);
      end
      last_same_nxt = wheel_a;
      moved = 1'b1;
    end
  end

  assign stat.moved = moved;
  assign stat.total = total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_same_r <= 1'b0;
      last_diff_r <= 1'b0;
      total_r <= '0;
    end else if (adv) begin
      last_same_r <= last_same_nxt;
      last_diff_r <= last_diff_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

/* hw/rtl/prfe_debounce.sv */
// release-only button debounce with saturating per-button counters
module prfe_debounce
  import prfe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic [CNT_W-1:0]       dbnc_limit,
  input  logic [BTN_FIELD_W-1:0] button_level,
  input  logic [BTN_FIELD_W-1:0] button_edge,
  input  logic [NUM_BUTTONS-1:0] prev_buttons,
  output logic [NUM_BUTTONS-1:0] dbncd
);

  logic [CNT_W-1:0] count_r [NUM_BUTTONS];
  logic [CNT_W-1:0] count_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS+BTN_FIELD_W-1:0] unpressed_ext;
  logic [NUM_BUTTONS-1:0] unpressed;

  // button bits beyond the input field read as pressed
  assign unpressed_ext = {{NUM_BUTTONS{1'b0}}, button_level & ~button_edge};
  assign unpressed = unpressed_ext[NUM_BUTTONS-1:0];

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (prev_buttons[i] && unpressed[i]) begin
        count_nxt[i] = (count_r[i] < dbnc_limit) ? count_r[i] + CNT_W'(1) : count_r[i];
        dbncd[i] = (count_nxt[i] < dbnc_limit);
      end else begin
        count_nxt[i] = '0;
        dbncd[i] = ~unpressed[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        count_r[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        count_r[i] <= count_nxt[i];
      end
    end
  end

endmodule

/* hw/rtl/pointer_report_frame_engine.sv */
// Pointer report frame engine, top level.
// One input item is one frame: wheel A/B levels, button levels and edge
// flags, and sensor dx/dy. For every item exactly one result item comes
// out: send, ack_request, status_byte, the wrapping pos_x/pos_y/wheel_pos
// totals and sleep.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. Configuration (debounce limit, sleep timeout) is written through
// cfg_we/cfg_index/cfg_wdata; the user must write it only while the block
// is idle; the block itself does not enforce this. A taken item is held in
// the input register and its result in the output register; the frame
// logic between them is one pass. Throughput is one item per cycle unless
// the receiver stalls; then the result holds in the output register, one
// more item waits in the input register, then in_stall rises.
// Synchronous active-low reset empties both registers, clears all totals,
// counters and stored buttons, sets the first-frame mark and loads a
// debounce limit of 16 and a sleep timeout of 240.
module pointer_report_frame_engine
  import prfe_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_wheel_a,
  input  logic                      in_wheel_b,
  input  logic [BTN_FIELD_W-1:0]    in_button_level,
  input  logic [BTN_FIELD_W-1:0]    in_button_edge,
  input  logic signed [DELTA_W-1:0] in_delta_x,
  input  logic signed [DELTA_W-1:0] in_delta_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_send,
  output logic                      out_ack_request,
  output logic [STATUS_W-1:0]       out_status_byte,
  output logic signed [DELTA_W-1:0] out_pos_x,
  output logic signed [DELTA_W-1:0] out_pos_y,
  output logic signed [WHEEL_W-1:0] out_wheel_pos,
  output logic                      out_sleep,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

  logic [CNT_W-1:0] dbnc_limit_r;
  logic [CNT_W-1:0] sleep_timeout_r;

  // input register
  logic                   in_valid_r;
  logic                   wheel_a_r, wheel_b_r;
  logic [BTN_FIELD_W-1:0] level_r, edge_r;
  logic [DELTA_W-1:0]     dx_r, dy_r;

  // frame state
  logic [NUM_BUTTONS-1:0] prev_buttons_r;
  logic [DELTA_W-1:0]     x_total_r, y_total_r;
  logic [CNT_W-1:0]       frame_count_r, idle_count_r;
  logic                   first_flag_r;

  // output register
  logic out_valid_r;

  logic                   adv;
  wheel_stat_t            wheel;
  logic [NUM_BUTTONS-1:0] dbncd;
  logic [DELTA_W-1:0]     x_nxt, y_nxt;
  logic [CNT_W-1:0]       idle_inc, idle_nxt;
  logic                   changed, send, sleep, fc_zero, fc_one;
  logic [NUM_BUTTONS+STATUS_W-1:0] btn_ext;
  logic [STATUS_W-1:0]    status;

  assign adv = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbnc_limit_r <= DEBOUNCE_RESET;
      sleep_timeout_r <= SLEEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DBNC_LIMIT: dbnc_limit_r <= cfg_wdata;
        REG_SLEEP_TIMEOUT: sleep_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      wheel_a_r <= in_wheel_a;
      wheel_b_r <= in_wheel_b;
      level_r <= in_button_level;
      edge_r <= in_button_edge;
      dx_r <= in_delta_x;
      dy_r <= in_delta_y;
    end
  end

  prfe_wheel u_wheel (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .wheel_a (wheel_a_r),
    .wheel_b (wheel_b_r),
    .stat    (wheel)
  );

  prfe_debounce u_debounce (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .dbnc_limit    (dbnc_limit_r),
    .button_level  (level_r),
    .button_edge   (edge_r),
    .prev_buttons  (prev_buttons_r),
    .dbncd         (dbncd)
  );

  assign x_nxt = x_total_r + dx_r;
  assign y_nxt = y_total_r + dy_r;
  assign fc_zero = (frame_count_r == '0);
  assign fc_one = (frame_count_r == CNT_W'(1));

  assign changed = (dbncd != prev_buttons_r) || (dx_r != '0) || (dy_r != '0) || wheel.moved;
  assign idle_inc = fc_zero ? idle_count_r + CNT_W'(1) : idle_count_r;
  assign idle_nxt = changed ? '0 : idle_inc;
  assign sleep = (idle_nxt > sleep_timeout_r);
  assign send = changed || fc_zero || fc_one;

  assign btn_ext = {{STATUS_W{1'b0}}, dbncd};
  assign status = btn_ext[STATUS_W-1:0]
                | (first_flag_r ? STATUS_FIRST : '0)
                | (fc_zero ? STATUS_SYNC : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_buttons_r <= '0;
      x_total_r <= '0;
      y_total_r <= '0;
      frame_count_r <= '0;
      idle_count_r <= '0;
      first_flag_r <= 1'b1;
    end else if (adv) begin
      if (send) begin
        prev_buttons_r <= dbncd;
      end
      x_total_r <= x_nxt;
      y_total_r <= y_nxt;
      first_flag_r <= 1'b0;
      if (sleep) begin
        frame_count_r <= CNT_W'(1);
        idle_count_r <= '0;
      end else begin
        frame_count_r <= frame_count_r + CNT_W'(1);
        idle_count_r <= idle_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_send <= send;
      out_ack_request <= send && fc_one;
      out_status_byte <= status;
      out_pos_x <= x_nxt;
      out_pos_y <= y_nxt;
      out_wheel_pos <= wheel.total;
      out_sleep <= sleep;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* dv/tb_pointer_report_frame_engine.sv */
// self-checking testbench for the pointer report frame engine: directed table, then random frames
module tb_pointer_report_frame_engine
  import prfe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                   wa;
    logic                   wb;
    logic [BTN_FIELD_W-1:0] level;
    logic [BTN_FIELD_W-1:0] btn_edge;
    logic [DELTA_W-1:0]     dx;
    logic [DELTA_W-1:0]     dy;
  } frame_t;

  typedef struct packed {
    logic                send;
    logic                ack;
    logic [STATUS_W-1:0] status;
    logic [DELTA_W-1:0]  px;
    logic [DELTA_W-1:0]  py;
    logic [WHEEL_W-1:0]  wheel;
    logic                sleep;
  } report_t;

  typedef struct {
    frame_t  f;
    bit      typed;
    report_t r;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_wheel_a = 1'b0;
  logic                      in_wheel_b = 1'b0;
  logic [BTN_FIELD_W-1:0]    in_button_level = '0;
  logic [BTN_FIELD_W-1:0]    in_button_edge = '0;
  logic signed [DELTA_W-1:0] in_delta_x = '0;
  logic signed [DELTA_W-1:0] in_delta_y = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_send;
  logic                      out_ack_request;
  logic [STATUS_W-1:0]       out_status_byte;
  logic signed [DELTA_W-1:0] out_pos_x;
  logic signed [DELTA_W-1:0] out_pos_y;
  logic signed [WHEEL_W-1:0] out_wheel_pos;
  logic                      out_sleep;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;

  pointer_report_frame_engine u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_wheel_a      (in_wheel_a),
    .in_wheel_b      (in_wheel_b),
    .in_button_level (in_button_level),
    .in_button_edge  (in_button_edge),
    .in_delta_x      (in_delta_x),
    .in_delta_y      (in_delta_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_send        (out_send),
    .out_ack_request (out_ack_request),
    .out_status_byte (out_status_byte),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_wheel_pos   (out_wheel_pos),
    .out_sleep       (out_sleep),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state and configuration
  logic [CNT_W-1:0]       debounce_cfg = DEBOUNCE_RESET;
  logic [CNT_W-1:0]       sleep_cfg = SLEEP_RESET;
  logic [NUM_BUTTONS-1:0] pred_buttons = '0;
  logic [CNT_W-1:0]       rel_cnt [NUM_BUTTONS];
  logic                   whl_same = 1'b0;
  logic                   whl_diff = 1'b0;
  logic [WHEEL_W-1:0]     whl_tot = '0;
  logic [DELTA_W-1:0]     x_tot = '0;
  logic [DELTA_W-1:0]     y_tot = '0;
  logic [CNT_W-1:0]       frm_cnt = '0;
  logic [CNT_W-1:0]       idle_cnt = '0;
  logic                   first_frm = 1'b1;

  report_t   expected_reports[$];
  int        mismatches = 0;
  dir_row_t  dir_table[$];

  // stimulus generator state
  logic [1:0]             wheel_ph = 2'd0;
  logic [BTN_FIELD_W-1:0] cur_level = '1;
  int                     burst_left = 0;
  int                     rx_left = 0;

  task automatic predict_report(input frame_t f, output report_t r);
    logic                   moved;
    logic [BTN_FIELD_W-1:0] unpr;
    logic [NUM_BUTTONS-1:0] dbn;
    logic                   chg;
    logic                   snd;
    logic                   slp;
    logic [STATUS_W-1:0]    st;
    moved = 1'b0;
    dbn = '0;
    slp = 1'b0;
    if (f.wa != f.wb) begin
      whl_diff = f.wa;
    end else if (f.wa != whl_same) begin
      if (f.wa ^ whl_diff) whl_tot = whl_tot + WHEEL_W'(1);
      else whl_tot = whl_tot - WHEEL_W'(1);
      whl_same = f.wa;
      moved = 1'b1;
    end
    unpr = f.level & ~f.btn_edge;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (pred_buttons[i] && unpr[i]) begin
        if (rel_cnt[i] < debounce_cfg) rel_cnt[i] = rel_cnt[i] + CNT_W'(1);
        if (rel_cnt[i] < debounce_cfg) dbn[i] = 1'b1;
      end else begin
        rel_cnt[i] = '0;
        dbn[i] = ~unpr[i];
      end
    end
    x_tot = x_tot + f.dx;
    y_tot = y_tot + f.dy;
    if (frm_cnt == 0) idle_cnt = idle_cnt + CNT_W'(1);
    chg = (dbn != pred_buttons) || (f.dx != 0) || (f.dy != 0) || moved;
    if (chg) idle_cnt = '0;
    snd = chg || (frm_cnt <= 1);
    if (snd) pred_buttons = dbn;
    st = STATUS_W'(dbn);
    if (first_frm) st = st | STATUS_FIRST;
    if (frm_cnt == 0) st = st | STATUS_SYNC;
    r.send = snd;
    r.ack = snd && (frm_cnt == 1);
    r.status = st;
    r.px = x_tot;
    r.py = y_tot;
    r.wheel = whl_tot;
    if (idle_cnt > sleep_cfg) begin
      slp = 1'b1;
      frm_cnt = '0;
      idle_cnt = '0;
    end
    r.sleep = slp;
    first_frm = 1'b0;
    frm_cnt = frm_cnt + CNT_W'(1);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  function automatic frame_t mk(input logic a, input logic b, input logic [2:0] lvl,
                                input logic [2:0] edg, input logic [15:0] dx,
                                input logic [15:0] dy);
    frame_t f;
    f.wa = a;
    f.wb = b;
    f.level = lvl;
    f.btn_edge = edg;
    f.dx = dx;
    f.dy = dy;
    return f;
  endfunction

  function automatic logic [15:0] pick_delta();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'h0000;
      4:          return 16'h7FFF;
      5:          return 16'h8000;
      6, 7:       return 16'($urandom_range(0, 15)) - 16'd8;
      default:    return 16'($urandom);
    endcase
  endfunction

  task automatic next_frame(input bit quiet, output frame_t f);
    if (!quiet) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: wheel_ph = wheel_ph + ($urandom_range(0, 1) ? 2'd1 : 2'd3);
        6:                wheel_ph = 2'($urandom);
        default: ;
      endcase
      for (int i = 0; i < BTN_FIELD_W; i++)
        if ($urandom_range(0, 15) == 0) cur_level[i] = ~cur_level[i];
    end
    case (wheel_ph)
      2'd0:    {f.wa, f.wb} = 2'b00;
      2'd1:    {f.wa, f.wb} = 2'b10;
      2'd2:    {f.wa, f.wb} = 2'b11;
      default: {f.wa, f.wb} = 2'b01;
    endcase
    f.level = cur_level;
    if (quiet) begin
      f.btn_edge = '0;
      f.dx = '0;
      f.dy = '0;
    end else begin
      f.btn_edge = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0;
      f.dx = pick_delta();
      f.dy = pick_delta();
    end
  endtask

  task automatic send_frame(input frame_t f, input bit typed, input report_t typed_r);
    report_t pr;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_wheel_a <= f.wa;
    in_wheel_b <= f.wb;
    in_button_level <= f.level;
    in_button_edge <= f.btn_edge;
    in_delta_x <= f.dx;
    in_delta_y <= f.dy;
    do @(posedge clk); while (in_stall);
    predict_report(f, pr);
    expected_reports.push_back(typed ? typed_r : pr);
  endtask

  task automatic write_cfg(input logic [CFG_DATA_W-1:0] dbt,
                           input logic [CFG_DATA_W-1:0] slp);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_DBNC_LIMIT;
    cfg_wdata <= dbt;
    @(posedge clk);
    cfg_index <= REG_SLEEP_TIMEOUT;
    cfg_wdata <= slp;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_cfg = dbt;
    sleep_cfg = slp;
    burst_left = 0;
  endtask

  task automatic run_random(input int count, input int quiet_from, input int quiet_to);
    frame_t f;
    for (int n = 0; n < count; n++) begin
      next_frame((n >= quiet_from) && (n < quiet_to), f);
      send_frame(f, 1'b0, '0);
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rx_left == 0) begin
      if (out_stall || $urandom_range(0, 1)) begin
        out_stall <= 1'b0;
        rx_left = $urandom_range(1, 40);
      end else begin
        out_stall <= 1'b1;
        rx_left = $urandom_range(1, 6);
      end
    end else begin
      rx_left--;
    end
  end

  // result checker
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.send = out_send;
      got.ack = out_ack_request;
      got.status = out_status_byte;
      got.px = out_pos_x;
      got.py = out_pos_y;
      got.wheel = out_wheel_pos;
      got.sleep = out_sleep;
      if (expected_reports.size() == 0) begin
        report_mismatch("item with none expected", 16'(got.status), 16'h0);
      end else begin
        want = expected_reports.pop_front();
        if (got.send !== want.send) report_mismatch("send", 16'(got.send), 16'(want.send));
        if (got.ack !== want.ack) report_mismatch("ack_request", 16'(got.ack), 16'(want.ack));
        if (got.status !== want.status)
          report_mismatch("status_byte", 16'(got.status), 16'(want.status));
        if (got.px !== want.px) report_mismatch("pos_x", got.px, want.px);
        if (got.py !== want.py) report_mismatch("pos_y", got.py, want.py);
        if (got.wheel !== want.wheel)
          report_mismatch("wheel_pos", 16'(got.wheel), 16'(want.wheel));
        if (got.sleep !== want.sleep)
          report_mismatch("sleep", 16'(got.sleep), 16'(want.sleep));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_BUTTONS; i++) rel_cnt[i] = '0;

    // first frame, full-scale deltas, wrap of both totals
    dir_table.push_back('{mk(0, 0, 3'd0, 3'd0, 16'h0000, 16'h0000), 1'b1,
                         '{1'b1, 1'b0, 8'hC7, 16'h0000, 16'h0000, 8'h00, 1'b0}});
    dir_table.push_back('{mk(0, 0, 3'd7, 3'd0, 16'h7FFF, 16'h8000), 1'b1,
                         '{1'b1, 1'b1, 8'h07, 16'h7FFF, 16'h8000, 8'h00, 1'b0}});
    dir_table.push_back('{mk(0, 0, 3'd7, 3'd0, 16'h0001, 16'h8000), 1'b1,
                         '{1'b1, 1'b0, 8'h07, 16'h8000, 16'h0000, 8'h00, 1'b0}});
    // edges mask releases
    dir_table.push_back('{mk(0, 0, 3'd7, 3'd7, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(0, 0, 3'd0, 3'd0, 16'hFFFF, 16'h0001), 1'b0, '0});
    // wheel forward then backward in half steps
    dir_table.push_back('{mk(1, 0, 3'd0, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(1, 1, 3'd0, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(0, 1, 3'd0, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(0, 0, 3'd0, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(0, 1, 3'd0, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(1, 1, 3'd0, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(1, 0, 3'd0, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(0, 0, 3'd0, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});
    // jump straight across
    dir_table.push_back('{mk(1, 1, 3'd0, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(1, 1, 3'd5, 3'd2, 16'h8000, 16'h7FFF), 1'b0, '0});
    dir_table.push_back('{mk(1, 1, 3'd2, 3'd4, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(1, 1, 3'd7, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(1, 1, 3'd7, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(1, 1, 3'd0, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});
    dir_table.push_back('{mk(1, 1, 3'd0, 3'd0, 16'h0000, 16'h0000), 1'b0, '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[k]) send_frame(dir_table[k].f, dir_table[k].typed, dir_table[k].r);

    // shortest settings, long quiet run to reach sleep
    write_cfg(8'd1, 8'd1);
    run_random(650, 40, 640);

    // longest settings
    write_cfg(8'd255, 8'd254);
    run_random(250, 0, 0);

    write_cfg(8'($urandom_range(2, 24)), 8'($urandom_range(1, 254)));
    run_random(430, 200, 230);

    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
